// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CRK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define CRK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/crk_pkg.sv =====
`default_nettype none

package crk_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 7;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    typedef struct packed {
        logic              load;
        logic [RANK_W-1:0] rank;
        logic              end_of_set;
        logic              overflow;
    } out_load_t;

endpackage

`default_nettype wire

// ===== design/crk_ram.sv =====
`default_nettype none

module crk_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/crk_out.sv =====
`default_nettype none

module crk_out (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire crk_pkg::out_load_t        ld,
    output logic                           free,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [crk_pkg::RANK_W-1:0]     rank,
    output logic                           end_of_set,
    output logic                           overflow
);

    import crk_pkg::*;

    logic              valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              eos_reg;
    logic              ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            rank_reg <= ld.rank;
            eos_reg  <= ld.end_of_set;
            ovf_reg  <= ld.overflow;
        end
    end

    // Slot can take a new result when empty or when its transfer completes now.
    assign free       = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign rank       = rank_reg;
    assign end_of_set = eos_reg;
    assign overflow   = ovf_reg;

endmodule

`default_nettype wire

// ===== design/competition_rank_engine.sv =====
// Competition rank engine: loads a set of signed 32-bit keys and returns, in
// load order, each key's rank (1 + number of stored keys strictly smaller).
// Input channel: in_valid/in_stall carrying key and final_req; a transfer
// happens when in_valid is high and in_stall low. The block holds in_stall
// while it works on a key or emits results.
// Output channel: out_valid/out_stall carrying rank, end_of_set, overflow.
// After a key is taken, in_stall stays high while the block reads every stored
// key through the single read port of each memory, collects the last read and
// writes the new key's count. For the first key of a set, in_stall covers only
// the count write.
// After the final key's sweep, or after a dropped final key, results leave at
// one per cycle while the receiver does not stall; out_valid rises once the
// first count read has been loaded into the output register. A stall holds
// the output register and pauses the read stream; nothing is lost.
// Keys beyond 64 are dropped and every result of that set shows overflow.
// Reset empties the store at once (no clearing pass); memory contents are
// left as they are and only entries of the current set are read.
`default_nettype none

module competition_rank_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [crk_pkg::KEY_W-1:0]  key,
    input  wire logic                              final_req,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [crk_pkg::RANK_W-1:0]             rank,
    output logic                                   end_of_set,
    output logic                                   overflow
);

    import crk_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]              state_reg,   state_next;
    logic [CNT_W-1:0]        stored_reg,  stored_next;
    logic                    dropped_reg, dropped_next;
    logic                    final_reg,   final_next;
    logic [CNT_W-1:0]        rd_idx_reg,  rd_idx_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]        wb_idx_reg,  wb_idx_next;
    logic [CNT_W-1:0]        acc_reg,     acc_next;
    logic [CNT_W-1:0]        emit_n_reg,  emit_n_next;
    logic signed [KEY_W-1:0] newkey_reg;

    logic                    accept;
    logic                    key_we;
    logic                    key_re;
    logic signed [KEY_W-1:0] key_rdata;
    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_waddr;
    logic [CNT_W-1:0]        cnt_wdata;
    logic                    cnt_re;
    logic [CNT_W-1:0]        cnt_rdata;
    logic                    out_free;
    logic                    issue;
    out_load_t               ld;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    crk_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_mem (
        .clk   (clk),
        .we    (key_we),
        .waddr (stored_reg[IDX_W-1:0]),
        .wdata (key),
        .re    (key_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    crk_ram #(.WIDTH(CNT_W), .DEPTH(MAX_KEYS)) u_cnt_mem (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (cnt_rdata)
    );

    crk_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rank       (rank),
        .end_of_set (end_of_set),
        .overflow   (overflow)
    );

    always_comb
    begin
        state_next   = state_reg;
        stored_next  = stored_reg;
        dropped_next = dropped_reg;
        final_next   = final_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = rd_pend_reg;
        wb_idx_next  = wb_idx_reg;
        acc_next     = acc_reg;
        emit_n_next  = emit_n_reg;
        key_we       = 1'b0;
        key_re       = 1'b0;
        cnt_we       = 1'b0;
        cnt_waddr    = wb_idx_reg;
        cnt_wdata    = cnt_rdata + CNT_W'(1);
        cnt_re       = 1'b0;
        issue        = 1'b0;
        ld           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stored_reg < CNT_W'(MAX_KEYS))
                    begin
                        key_we      = 1'b1;
                        final_next  = final_req;
                        rd_idx_next = '0;
                        acc_next    = '0;
                        state_next  = ST_SWEEP;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        if (final_req)
                        begin
                            emit_n_next = stored_reg;
                            rd_idx_next = '0;
                            state_next  = ST_EMIT;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                // Read entry rd_idx, write back entry wb_idx in the cycle after.
                issue        = (rd_idx_reg < stored_reg);
                key_re       = issue;
                cnt_re       = issue;
                rd_pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    wb_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if (rd_pend_reg)
                begin
                    if (key_rdata < newkey_reg)
                    begin
                        acc_next = acc_reg + CNT_W'(1);
                    end
                    else if (newkey_reg < key_rdata)
                    begin
                        cnt_we = 1'b1;
                    end
                end
                else if (!issue)
                begin
                    cnt_we      = 1'b1;
                    cnt_waddr   = stored_reg[IDX_W-1:0];
                    cnt_wdata   = acc_reg;
                    stored_next = stored_reg + CNT_W'(1);
                    if (final_reg)
                    begin
                        emit_n_next = stored_reg + CNT_W'(1);
                        rd_idx_next = '0;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                ld.load       = rd_pend_reg && out_free;
                ld.rank       = RANK_W'(cnt_rdata) + RANK_W'(1);
                ld.end_of_set = ((CNT_W'(wb_idx_reg) + CNT_W'(1)) == emit_n_reg);
                ld.overflow   = dropped_reg;
                issue         = (rd_idx_reg < emit_n_reg) && (!rd_pend_reg || ld.load);
                cnt_re        = issue;
                rd_pend_next  = issue || (rd_pend_reg && !ld.load);
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    wb_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if ((rd_idx_reg == emit_n_reg) && (!rd_pend_reg || ld.load))
                begin
                    stored_next  = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            stored_reg  <= '0;
            dropped_reg <= 1'b0;
            final_reg   <= 1'b0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            wb_idx_reg  <= '0;
            acc_reg     <= '0;
            emit_n_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            stored_reg  <= stored_next;
            dropped_reg <= dropped_next;
            final_reg   <= final_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
            wb_idx_reg  <= wb_idx_next;
            acc_reg     <= acc_next;
            emit_n_reg  <= emit_n_next;
        end
    end

    // Hold the key under comparison for the whole sweep.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            newkey_reg <= key;
        end
    end

endmodule

`default_nettype wire

// ===== design/crk_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module crk_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic signed [crk_pkg::KEY_W-1:0]  key,
    input  wire logic                              final_req,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [crk_pkg::RANK_W-1:0]        rank,
    input  wire logic                              end_of_set,
    input  wire logic                              overflow
);

    import crk_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall && (key == key) && (final_req == final_req);

    `CRK_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "output dropped while stalled")
    `CRK_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(rank) && $stable(end_of_set) && $stable(overflow), "stalled result changed")
    `CRK_ASSERT_IMP(a_rank_range, out_valid, (rank != '0) && (rank <= RANK_W'(MAX_KEYS)), "rank out of range")
    `CRK_ASSERT_IMP(a_no_load_mid_set, out_valid && !end_of_set, in_stall && !in_xfer, "key taken while results pending")

endmodule

bind competition_rank_engine crk_checker u_crk_checker (.*);

`default_nettype wire
